FILE: hw/rtl/expg_pkg.sv
// ----------------------------------------------------------------------------
// expg_pkg
// Shared types and constants for the order-0 exp-golomb encoder and packer.
// ----------------------------------------------------------------------------
package expg_pkg;

    localparam int VALUE_W    = 32;
    localparam int LEN_W      = 6;
    localparam int WORD_W     = 64;
    localparam int VBITS_W    = 7;
    localparam int TOTAL_W    = 40;
    localparam int QUEUE_DEPTH = 4;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    localparam logic [VALUE_W-1:0] VALUE_BAD = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [VBITS_W-1:0] FULL_BITS = VBITS_W'(WORD_W);

    typedef struct packed {
        logic               kind;
        logic               err;
        logic [VALUE_W-1:0] code;
        logic [LEN_W-1:0]   len;
    } item_t;

endpackage

FILE: hw/rtl/expg_classify.sv
// ----------------------------------------------------------------------------
// expg_classify
// Front end: sorts a request into flush, error or encode and forms the code
// word x = v + 1 with its length 2*floor(log2 x) + 1.
// ----------------------------------------------------------------------------
module expg_classify
(
    input  logic                            kind,
    input  logic [expg_pkg::VALUE_W-1:0]    value,
    output expg_pkg::item_t                 item
);

    logic [expg_pkg::VALUE_W-1:0] x;
    logic [4:0]                   lz;

    assign x = value + expg_pkg::VALUE_W'(1);

    always_comb
    begin
        lz = '0;
        for (int i = 0; i < expg_pkg::VALUE_W; i++)
        begin
            if (x[i])
            begin
                lz = 5'(i);
            end
        end
    end

    always_comb
    begin
        item.kind = kind;
        item.err  = (kind == expg_pkg::KIND_ENCODE) && (value == expg_pkg::VALUE_BAD);
        item.code = x;
        item.len  = {lz, 1'b1};
    end

endmodule

FILE: hw/rtl/expg_queue.sv
// ----------------------------------------------------------------------------
// expg_queue
// Short request queue between the classifier and the packer.
// ----------------------------------------------------------------------------
module expg_queue
#(
    parameter int DEPTH = expg_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  expg_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output expg_pkg::item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    expg_pkg::item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: hw/rtl/expg_pack.sv
// ----------------------------------------------------------------------------
// expg_pack
// Back end: merges codes into the pending 64-bit word, keeps the running
// stream length and holds the result register.
// ----------------------------------------------------------------------------
module expg_pack
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  expg_pkg::item_t                 in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [expg_pkg::WORD_W-1:0]     out_word,
    output logic [expg_pkg::VBITS_W-1:0]    out_vbits,
    output logic                            out_last,
    output logic                            out_err,
    output logic [expg_pkg::TOTAL_W-1:0]    out_total
);

    localparam int W  = expg_pkg::WORD_W;
    localparam int VW = expg_pkg::VBITS_W;
    localparam int TW = expg_pkg::TOTAL_W;

    logic [W-1:0]     pend_reg, pend_next;
    logic [5:0]       fill_reg, fill_next;
    logic [TW-1:0]    total_reg, total_next;
    logic             ovalid_reg, ovalid_next;
    logic [W-1:0]     oword_reg, oword_next;
    logic [VW-1:0]    ovbits_reg, ovbits_next;
    logic             olast_reg, olast_next;
    logic             oerr_reg, oerr_next;
    logic [TW-1:0]    ototal_reg, ototal_next;

    logic             take;
    logic [TW:0]      total_sum;
    logic [TW-1:0]    total_sat;
    logic [VW-1:0]    fill_sum;
    logic [7:0]       shamt;
    logic [2*W-1:0]   merged;

    assign in_ready = !ovalid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign total_sum = {1'b0, total_reg} + (TW+1)'(in_item.len);
    assign total_sat = total_sum[TW] ? expg_pkg::TOTAL_MAX : total_sum[TW-1:0];
    assign fill_sum  = VW'(fill_reg) + VW'(in_item.len);
    assign shamt     = 8'(2*W) - 8'(fill_sum);
    assign merged    = {pend_reg, {W{1'b0}}}
                     | ({{(2*W-expg_pkg::VALUE_W){1'b0}}, in_item.code} << shamt[6:0]);

    always_comb
    begin
        pend_next   = pend_reg;
        fill_next   = fill_reg;
        total_next  = total_reg;
        ovalid_next = ovalid_reg && !out_ready;
        oword_next  = oword_reg;
        ovbits_next = ovbits_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        ototal_next = ototal_reg;
        if (take)
        begin
            if (in_item.kind == expg_pkg::KIND_FLUSH)
            begin
                ovalid_next = 1'b1;
                oword_next  = pend_reg;
                ovbits_next = VW'(fill_reg);
                olast_next  = 1'b1;
                oerr_next   = 1'b0;
                ototal_next = total_reg;
                pend_next   = '0;
                fill_next   = '0;
                total_next  = '0;
            end
            else if (in_item.err)
            begin
                ovalid_next = 1'b1;
                oword_next  = '0;
                ovbits_next = '0;
                olast_next  = 1'b0;
                oerr_next   = 1'b1;
                ototal_next = total_reg;
            end
            else
            begin
                total_next = total_sat;
                if (fill_sum < expg_pkg::FULL_BITS)
                begin
                    pend_next = merged[2*W-1:W];
                    fill_next = fill_sum[5:0];
                end
                else
                begin
                    pend_next   = merged[W-1:0];
                    fill_next   = 6'(fill_sum - expg_pkg::FULL_BITS);
                    ovalid_next = 1'b1;
                    oword_next  = merged[2*W-1:W];
                    ovbits_next = expg_pkg::FULL_BITS;
                    olast_next  = 1'b0;
                    oerr_next   = 1'b0;
                    ototal_next = total_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            fill_reg   <= '0;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pend_reg   <= pend_next;
            fill_reg   <= fill_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oword_reg  <= oword_next;
        ovbits_reg <= ovbits_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
        ototal_reg <= ototal_next;
    end

    assign out_valid = ovalid_reg;
    assign out_word  = oword_reg;
    assign out_vbits = ovbits_reg;
    assign out_last  = olast_reg;
    assign out_err   = oerr_reg;
    assign out_total = ototal_reg;

endmodule

FILE: hw/rtl/exp_golomb_ue_encoder_packer.sv
// ----------------------------------------------------------------------------
// exp_golomb_ue_encoder_packer
// Order-0 exp-golomb (ue) encoder that packs codes msb-first into 64-bit words.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the queue has room: s_tuser high is
// a flush, otherwise s_tdata is a code number. A result reaches the master
// side through a queue entry and then the result register in the packer; the
// rate of one request per cycle is set by the combinational 128-bit
// shift-and-merge in the packer. A queue of DEPTH entries sits between the
// classifier and the packer, so the slave side can take up to DEPTH more
// requests while a result waits on a stalled master side. The code number
// 0xFFFFFFFF is not encoded and returns a result with m_tuser high.
// ----------------------------------------------------------------------------
module exp_golomb_ue_encoder_packer
#(
    parameter int DEPTH = expg_pkg::QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // value
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // word, valid_bits, total_bits, zero pad
    output logic         m_tlast,
    output logic         m_tuser    // error
);

    expg_pkg::item_t                cls_item;
    expg_pkg::item_t                q_item;
    logic                           q_valid, q_ready;
    logic [expg_pkg::WORD_W-1:0]    word;
    logic [expg_pkg::VBITS_W-1:0]   valid_bits;
    logic [expg_pkg::TOTAL_W-1:0]   total_bits;

    expg_classify u_classify
    (
        .kind  (s_tuser),
        .value (s_tdata),
        .item  (cls_item)
    );

    expg_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_item  (cls_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    expg_pack u_pack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (word),
        .out_vbits (valid_bits),
        .out_last  (m_tlast),
        .out_err   (m_tuser),
        .out_total (total_bits)
    );

    assign m_tdata = {1'b0, total_bits, valid_bits, word};

endmodule

FILE: tb/tb_exp_golomb_ue_encoder_packer.sv
// ----------------------------------------------------------------------------
// tb_exp_golomb_ue_encoder_packer
// Self-checking bench for the order-0 exp-golomb (ue) encoder and word packer.
// ----------------------------------------------------------------------------
// Each accepted request runs through a bit-level predictor of the packer:
// the code is packed msb-first into 64-bit words, and every full word, flush
// and rejected value queues an expected result. The checker compares every
// master-side result, field by field, with the oldest expected one. The
// request stream starts with hand-picked edge cases and goes on with random
// code lengths, rejected values and flushes. The sender runs in bursts, and
// the receiver stalls in segments of random density. There is one long
// receiver hold-off and there are sender pauses until no result is outstanding.
// ----------------------------------------------------------------------------
module tb_exp_golomb_ue_encoder_packer;

    localparam int RANDOM_REQUESTS = 950;
    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_CYCLES     = 200;
    localparam int TAIL_CYCLES     = 16;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        bit          drain;
    } request_t;

    typedef struct packed {
        logic        pad;
        logic [39:0] total;
        logic        last;
        logic        err;
        logic [6:0]  vbits;
        logic [63:0] word;
    } packed_word_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // value
    logic         s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;   // word, valid_bits, total_bits, zero pad
    logic         m_tlast;
    logic         m_tuser;   // error

    request_t     request_q[$];
    packed_word_t word_expect_q[$];

    // predictor state
    logic [63:0]  pend_word;
    int           pend_fill;
    logic [39:0]  stream_bits;

    request_t     next_req;
    int           burst_left;
    int           gap_left;
    int           hold_left;
    bit           hold_done;
    int           seg_left;
    int           stall_pct;
    int           idle_cycles;

    int           in_count;
    int           out_count;
    int           full_count;
    int           flush_count;
    int           reject_count;
    int           fail_count;

    exp_golomb_ue_encoder_packer DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic add_request(input logic kind, input logic [31:0] value,
                               input bit drain);
        request_t r;
        begin
            r.kind  = kind;
            r.value = value;
            r.drain = drain;
            request_q.insert(request_q.size(), r);
        end
    endtask

    task automatic pack_request(input logic kind, input logic [31:0] value);
        logic [63:0]  x;
        int           lz;
        int           n;
        int           space;
        int           rem;
        packed_word_t r;
        begin
            r = '0;
            if (kind == expg_pkg::KIND_FLUSH)
            begin
                r.word  = pend_word;
                r.vbits = 7'(pend_fill);
                r.last  = 1'b1;
                r.total = stream_bits;
                word_expect_q.insert(word_expect_q.size(), r);
                pend_word   = '0;
                pend_fill   = 0;
                stream_bits = '0;
            end
            else if (value == expg_pkg::VALUE_BAD)
            begin
                r.err   = 1'b1;
                r.total = stream_bits;
                word_expect_q.insert(word_expect_q.size(), r);
            end
            else
            begin
                x  = 64'(value) + 64'd1;
                lz = 0;
                for (int b = 0; b < 33; b++)
                begin
                    if (x[b])
                        lz = b;
                end
                n = 2 * lz + 1;
                if (expg_pkg::TOTAL_MAX - stream_bits < 40'(n))
                    stream_bits = expg_pkg::TOTAL_MAX;
                else
                    stream_bits = stream_bits + 40'(n);
                space = 64 - pend_fill;
                if (n < space)
                begin
                    pend_word = pend_word | (x << (space - n));
                    pend_fill = pend_fill + n;
                end
                else
                begin
                    rem       = n - space;
                    r.word    = pend_word | (x >> rem);
                    pend_word = (rem == 0) ? 64'd0 : (x << (64 - rem));
                    pend_fill = rem;
                    r.vbits   = expg_pkg::FULL_BITS;
                    r.total   = stream_bits;
                    word_expect_q.insert(word_expect_q.size(), r);
                end
            end
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= expg_pkg::KIND_ENCODE;
            burst_left <= 1;
            gap_left   <= 0;
            in_count   <= 0;
            pend_word   = '0;
            pend_fill   = 0;
            stream_bits = '0;
        end
        else if (s_tvalid && !s_tready)
        begin
            // hold the request
        end
        else
        begin
            if (s_tvalid)
            begin
                pack_request(s_tuser, s_tdata);
                in_count <= in_count + 1;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() > 0 &&
                     (!request_q[0].drain || word_expect_q.size() == 0))
            begin
                next_req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_req.value;
                s_tuser  <= next_req.kind;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
            seg_left  <= 0;
            stall_pct <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && in_count >= 300)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else if (seg_left == 0)
        begin
            seg_left <= $urandom_range(8, 64);
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
            m_tready <= 1'b1;
        end
        else
        begin
            seg_left <= seg_left - 1;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge clk or negedge rst_n)
    begin : check_results
        packed_word_t got;
        packed_word_t want;
        if (!rst_n)
        begin
            out_count    <= 0;
            full_count   <= 0;
            flush_count  <= 0;
            reject_count <= 0;
            fail_count   <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            got.word  = m_tdata[63:0];
            got.vbits = m_tdata[70:64];
            got.total = m_tdata[110:71];
            got.pad   = m_tdata[111];
            got.last  = m_tlast;
            got.err   = m_tuser;
            out_count <= out_count + 1;
            if (got.last)
                flush_count <= flush_count + 1;
            else if (got.err)
                reject_count <= reject_count + 1;
            else
                full_count <= full_count + 1;
            if (word_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word=%h vbits=%0d last=%b err=%b total=%0d",
                         $time, got.word, got.vbits, got.last, got.err, got.total);
                fail_count <= fail_count + 1;
            end
            else
            begin
                want = word_expect_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected word=%h vbits=%0d last=%b err=%b total=%0d pad=%b",
                             $time, want.word, want.vbits, want.last, want.err, want.total,
                             want.pad);
                    $display("%0t: actual   word=%h vbits=%0d last=%b err=%b total=%0d pad=%b",
                             $time, got.word, got.vbits, got.last, got.err, got.total,
                             got.pad);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        logic [32:0] x;
        int          lz;
        int          roll;
        int          leftover;

        rst_n = 1'b0;

        // edge cases
        add_request(expg_pkg::KIND_ENCODE, 32'h0000_0000, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h0000_0001, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h0000_0002, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h7FFF_FFFE, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h7FFF_FFFF, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, expg_pkg::VALUE_BAD, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'hFFFF_FFFE, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'hAAAA_AAAA, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h5555_5555, 1'b0);
        add_request(expg_pkg::KIND_FLUSH, expg_pkg::VALUE_BAD, 1'b0);
        add_request(expg_pkg::KIND_FLUSH, 32'h0000_0000, 1'b0);
        // exactly one word, nothing left over
        add_request(expg_pkg::KIND_ENCODE, 32'h7FFF_FFFF, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h0000_0000, 1'b0);
        add_request(expg_pkg::KIND_FLUSH, 32'hFFFF_0000, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, expg_pkg::VALUE_BAD, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h0000_FFFF, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h8000_0000, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'hFFFF_FFFE, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'hFFFF_FFFE, 1'b0);
        add_request(expg_pkg::KIND_ENCODE, 32'h0000_0006, 1'b0);
        add_request(expg_pkg::KIND_FLUSH, 32'h1234_5678, 1'b0);

        // random code lengths, rejected values and flushes
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                add_request(expg_pkg::KIND_FLUSH, $urandom, i == 500);
            else if (roll < 5)
                add_request(expg_pkg::KIND_ENCODE, expg_pkg::VALUE_BAD, i == 500);
            else if (roll < 15)
                add_request(expg_pkg::KIND_ENCODE, $urandom, i == 500);
            else
            begin
                lz = $urandom_range(0, 31);
                x  = (33'd1 << lz) | (33'($urandom) & ((33'd1 << lz) - 33'd1));
                add_request(expg_pkg::KIND_ENCODE, 32'(x - 33'd1), i == 0 || i == 500);
            end
        end
        add_request(expg_pkg::KIND_FLUSH, $urandom, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (word_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        leftover = word_expect_q.size();
        if (leftover != 0)
            $display("%0t: %0d expected results never arrived", $time, leftover);
        $display("requests sent: %0d, results checked: %0d", in_count, out_count);
        $display("full words: %0d, flushes: %0d, rejected values: %0d",
                 full_count, flush_count, reject_count);
        if (fail_count == 0 && leftover == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
